// ===== sv/ceq_pkg.sv =====
// ----------------------------------------------------------------------------
// ceq_pkg: shared types and constants for the coalescing event queue
// Holds the queue depth, operation codes, entry, command, result and state types, and a saturating add.
// ----------------------------------------------------------------------------
`default_nettype none
package ceq_pkg;
    localparam int QueueDepth = 512;
    localparam int IdxW = $clog2(QueueDepth);
    localparam int CntW = $clog2(QueueDepth + 1);

    typedef enum logic [1:0] {
        FUNC_PUSH  = 2'd0,
        FUNC_POP   = 2'd1,
        FUNC_FLUSH = 2'd2,
        FUNC_NOP   = 2'd3
    } func_t;

    typedef struct packed {
        logic [31:0] etype;
        logic [63:0] key;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] delta_x;
        logic [31:0] delta_y;
        logic [63:0] payload;
    } entry_t;

    typedef struct packed {
        func_t  func;
        logic   handled;
        logic   motion;
        entry_t ent;
    } cmd_t;

    typedef struct packed {
        logic        out_valid;
        entry_t      ent;
        logic [9:0]  pending_count;
        logic        dropped;
    } res_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_MERGE,
        ST_POP,
        ST_FLUSH,
        ST_DONE
    } state_t;

    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {a[31], a} + {b[31], b};
        if (s[32] != s[31]) begin
            sat_add32 = s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            sat_add32 = s[31:0];
        end
    endfunction
endpackage
`default_nettype wire

// ===== sv/ceq_front.sv =====
// ----------------------------------------------------------------------------
// ceq_front: input stage
// Accepts stream transfers, classifies motion types, and queues commands.
// ----------------------------------------------------------------------------
`default_nettype none
module ceq_front (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [319:0]  s_tdata,
    input  wire logic          s_tuser,
    input  wire logic [31:0]   ptr_code,
    input  wire logic [31:0]   fgr_code,
    output logic               cmd_valid,
    input  wire logic          cmd_ready,
    output ceq_pkg::cmd_t      cmd
);
    import ceq_pkg::*;

    cmd_t       q_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    cmd_t       c;
    logic       push, pop;

    always_comb begin
        c.func          = func_t'(s_tdata[1:0]);
        c.handled       = s_tuser;
        c.ent.etype     = s_tdata[33:2];
        c.ent.key       = s_tdata[97:34];
        c.ent.pos_x     = s_tdata[129:98];
        c.ent.pos_y     = s_tdata[161:130];
        c.ent.delta_x   = s_tdata[193:162];
        c.ent.delta_y   = s_tdata[225:194];
        c.ent.payload   = s_tdata[289:226];
        c.motion        = (c.ent.etype == ptr_code) || (c.ent.etype == fgr_code);
    end

    assign s_tready  = (cnt_reg != 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rp_reg];
    assign push      = s_tvalid && s_tready;
    assign pop       = cmd_valid && cmd_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wp_reg] <= c;
        end
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) wp_reg <= ~wp_reg;
            if (pop)  rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule
`default_nettype wire

// ===== sv/ceq_back.sv =====
// ----------------------------------------------------------------------------
// ceq_back: queue engine
// Runs push with coalescing search, pop and flush compaction over slot memory.
// ----------------------------------------------------------------------------
`default_nettype none
module ceq_back (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      cmd_valid,
    output logic           cmd_ready,
    input  wire ceq_pkg::cmd_t cmd,
    output logic           res_valid,
    input  wire logic      res_ready,
    output ceq_pkg::res_t  res
);
    import ceq_pkg::*;

    entry_t mem [QueueDepth];
    entry_t rd_reg;

    state_t          state_reg, state_next;
    cmd_t            cmd_reg, cmd_next;
    logic [IdxW-1:0] head_reg, head_next;
    logic [CntW-1:0] fill_reg, fill_next;
    logic [CntW-1:0] i_reg, i_next;
    logic [CntW-1:0] kept_reg, kept_next;
    logic [CntW-1:0] lim_reg, lim_next;
    logic            rdv_reg, rdv_next;
    logic [IdxW-1:0] rs_reg, rs_next;
    res_t            res_reg, res_next;
    logic            resv_reg, resv_next;

    logic            rd_en, wr_en;
    logic [IdxW-1:0] rd_addr, wr_addr;
    entry_t          wr_data;
    logic [IdxW-1:0] i_slot, k_slot;
    logic            hit;

    assign cmd_ready = (state_reg == ST_IDLE) && !resv_reg;
    assign res_valid = resv_reg;
    assign res       = res_reg;
    assign hit = (rd_reg.etype == cmd_reg.ent.etype) && (rd_reg.key == cmd_reg.ent.key);

    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        if (rd_en) rd_reg <= mem[rd_addr];
    end

    always_comb begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        head_next  = head_reg;
        fill_next  = fill_reg;
        i_next     = i_reg;
        kept_next  = kept_reg;
        lim_next   = lim_reg;
        rdv_next   = 1'b0;
        rs_next    = rs_reg;
        res_next   = res_reg;
        resv_next  = resv_reg;
        rd_en      = 1'b0;
        wr_en      = 1'b0;
        rd_addr    = head_reg;
        wr_addr    = head_reg;
        wr_data    = cmd_reg.ent;
        i_slot     = head_reg + i_reg[IdxW-1:0];
        k_slot     = head_reg + kept_reg[IdxW-1:0];
        if (resv_reg && res_ready) resv_next = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd_valid && cmd_ready) begin
                    cmd_next = cmd;
                    res_next = '0;
                    i_next   = '0;
                    kept_next = '0;
                    lim_next = fill_reg;
                    unique case (cmd.func)
                        FUNC_PUSH: begin
                            if (!cmd.handled) state_next = ST_DONE;
                            else if (cmd.motion) begin
                                i_next = fill_reg;
                                state_next = ST_SEARCH;
                            end else state_next = ST_MERGE;
                        end
                        FUNC_POP: begin
                            rd_en = 1'b1;
                            state_next = (fill_reg != '0) ? ST_POP : ST_DONE;
                        end
                        FUNC_FLUSH: state_next = ST_FLUSH;
                        default: state_next = ST_DONE;
                    endcase
                end
            end
            ST_SEARCH: begin
                // check the slot read last cycle, issue the next older one
                if (rdv_reg && hit) begin
                    wr_en   = 1'b1;
                    wr_addr = rs_reg;
                    wr_data = rd_reg;
                    wr_data.pos_x   = cmd_reg.ent.pos_x;
                    wr_data.pos_y   = cmd_reg.ent.pos_y;
                    wr_data.delta_x = sat_add32(rd_reg.delta_x, cmd_reg.ent.delta_x);
                    wr_data.delta_y = sat_add32(rd_reg.delta_y, cmd_reg.ent.delta_y);
                    state_next = ST_DONE;
                end else if (i_reg != '0) begin
                    rd_en    = 1'b1;
                    rd_addr  = head_reg + i_reg[IdxW-1:0] - 1'b1;
                    rs_next  = rd_addr;
                    rdv_next = 1'b1;
                    i_next   = i_reg - 1'b1;
                end else state_next = ST_MERGE;
            end
            ST_MERGE: begin
                if (fill_reg < CntW'(QueueDepth)) begin
                    wr_en   = 1'b1;
                    wr_addr = head_reg + fill_reg[IdxW-1:0];
                    fill_next = fill_reg + 1'b1;
                end else res_next.dropped = 1'b1;
                state_next = ST_DONE;
            end
            ST_POP: begin
                res_next.out_valid = 1'b1;
                res_next.ent       = rd_reg;
                head_next = head_reg + 1'b1;
                fill_next = fill_reg - 1'b1;
                state_next = ST_DONE;
            end
            ST_FLUSH: begin
                // read slot i, then on the next cycle keep or drop it
                if (rdv_reg) begin
                    if (rd_reg.etype != cmd_reg.ent.etype) begin
                        wr_en   = 1'b1;
                        wr_addr = k_slot;
                        wr_data = rd_reg;
                        kept_next = kept_reg + 1'b1;
                    end
                end
                if (i_reg < lim_reg) begin
                    rd_en    = 1'b1;
                    rd_addr  = i_slot;
                    rdv_next = 1'b1;
                    i_next   = i_reg + 1'b1;
                end else if (!rdv_reg) begin
                    fill_next  = kept_reg;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!resv_reg) begin
                    res_next.pending_count = 10'(fill_reg);
                    resv_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        cmd_reg  <= cmd_next;
        i_reg    <= i_next;
        kept_reg <= kept_next;
        lim_reg  <= lim_next;
        rs_reg   <= rs_next;
        res_reg  <= res_next;
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            head_reg  <= '0;
            fill_reg  <= '0;
            rdv_reg   <= 1'b0;
            resv_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            fill_reg  <= fill_next;
            rdv_reg   <= rdv_next;
            resv_reg  <= resv_next;
        end
    end
endmodule
`default_nettype wire

// ===== sv/coalescing_event_queue_top.sv =====
// Throughput: one operation at a time through the slot memory (one read and one write port).
// Reset: synchronous active-low aresetn empties the queue and restores codes.
// ----------------------------------------------------------------------------
// coalescing_event_queue_top: coalescing event queue
// Front stage, command queue and memory engine with register port.
// ----------------------------------------------------------------------------
`default_nettype none
module coalescing_event_queue_top (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // func, event_type, event_key, pos_x, pos_y, delta_x, delta_y, payload
    input  wire logic [295:0] s_tdata,
    // handled
    input  wire logic         s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // out_type, out_key, out_pos_x, out_pos_y, out_delta_x, out_delta_y,
    // out_payload, pending_count
    output logic [303:0]      m_tdata,
    // out_valid, dropped
    output logic [1:0]        m_tuser,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic         cfg_index,
    input  wire logic [31:0]  cfg_data
);
    import ceq_pkg::*;

    logic [31:0] ptr_reg, fgr_reg;
    logic        cmd_valid, cmd_ready, res_valid;
    cmd_t        cmd;
    res_t        res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg <= 32'd1024;
            fgr_reg <= 32'd1794;
        end else if (cfg_valid) begin
            if (cfg_index) fgr_reg <= cfg_data;
            else           ptr_reg <= cfg_data;
        end
    end

    ceq_front u_front (
        .aclk, .aresetn, .s_tvalid, .s_tready,
        .s_tdata({24'd0, s_tdata}), .s_tuser,
        .ptr_code(ptr_reg), .fgr_code(fgr_reg),
        .cmd_valid, .cmd_ready, .cmd
    );

    ceq_back u_back (
        .aclk, .aresetn, .cmd_valid, .cmd_ready, .cmd,
        .res_valid, .res_ready(m_tready), .res
    );

    assign m_tvalid = res_valid;
    assign m_tdata  = {6'd0, res.pending_count, res.ent.payload, res.ent.delta_y,
                       res.ent.delta_x, res.ent.pos_y, res.ent.pos_x,
                       res.ent.key, res.ent.etype};
    assign m_tuser  = {res.dropped, res.out_valid};
endmodule
`default_nettype wire

// ===== sv/ceq_checker.sv =====
// ----------------------------------------------------------------------------
// ceq_checker: port-level checks for the coalescing event queue
// Watches result stability under stall and field consistency at the top-level ports.
// ----------------------------------------------------------------------------
`default_nettype none
module ceq_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [303:0] m_tdata,
    input wire logic [1:0]   m_tuser
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("pop and drop together");
    a_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[297:288] <= 10'd512)
        else $error("pending count above depth");
    a_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tdata[297:288] == 10'd512)
        else $error("drop while not full");
endmodule

bind coalescing_event_queue_top ceq_checker u_ceq_checker (
    .aclk, .aresetn, .m_tvalid, .m_tready, .m_tdata, .m_tuser
);
`default_nettype wire

// ===== tb/coalescing_event_queue_top_test.sv =====
// ----------------------------------------------------------------------------
// coalescing_event_queue_top_test: self-checking bench for the event queue
// Drives push, pop and flush transfers over the input stream, predicts each
// result with a queue model of its own and compares every output transfer.
// Covers coalescing, delta saturation, full-queue drops, flush compaction and
// several motion-code settings, with random stalls on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module coalescing_event_queue_top_test;
    import ceq_pkg::*;

    localparam int WatchLimit = 20000;
    localparam int HoldCycles = 3000;
    localparam int DrainWait  = 2 * QueueDepth + 40;
    localparam int PendW      = 298 - 288;

    typedef struct {
        func_t       func;
        logic [31:0] etype;
        logic        handled;
        logic [63:0] key;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] delta_x;
        logic [31:0] delta_y;
        logic [63:0] payload;
    } event_item_t;

    typedef struct {
        logic        out_valid;
        entry_t      ent;
        logic [9:0]  pending;
        logic        dropped;
    } queue_result_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    wire          s_tready;
    logic [295:0] s_tdata = '0;
    logic         s_tuser = 1'b0;
    wire          m_tvalid;
    logic         m_tready = 1'b0;
    wire  [303:0] m_tdata;
    wire  [1:0]   m_tuser;
    logic         cfg_valid = 1'b0;
    wire          cfg_ready;
    logic         cfg_index = 1'b0;
    logic [31:0]  cfg_data = '0;

    coalescing_event_queue_top u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    event_item_t   pending_items[$];
    queue_result_t expected_results[$];
    entry_t        queue_image[$];
    event_item_t   cur_item;
    logic [31:0]   pointer_code = 32'd1024;
    logic [31:0]   finger_code  = 32'd1794;
    int            src_idle_pct = 18;
    int            snk_idle_pct = 67;
    logic          hold_req = 1'b0;
    int            hold_cnt = 0;
    int            error_count = 0;
    int            quiet_cycles = 0;

    function automatic logic [31:0] sat_sum(input logic [31:0] a, input logic [31:0] b);
        logic signed [32:0] s;
        s = $signed({a[31], a}) + $signed({b[31], b});
        if (s > 33'sd2147483647) return 32'h7FFF_FFFF;
        if (s < -33'sd2147483648) return 32'h8000_0000;
        return s[31:0];
    endfunction

    task automatic predict_result(input event_item_t it);
        queue_result_t r;
        entry_t        e;
        entry_t        kept[$];
        bit            merged;
        r = '{default: '0};
        if (it.func == FUNC_PUSH && it.handled) begin
            merged = 0;
            if (it.etype == pointer_code || it.etype == finger_code) begin
                for (int i = queue_image.size() - 1; i >= 0 && !merged; i--) begin
                    if (queue_image[i].etype == it.etype && queue_image[i].key == it.key) begin
                        queue_image[i].pos_x = it.pos_x;
                        queue_image[i].pos_y = it.pos_y;
                        queue_image[i].delta_x = sat_sum(queue_image[i].delta_x, it.delta_x);
                        queue_image[i].delta_y = sat_sum(queue_image[i].delta_y, it.delta_y);
                        merged = 1;
                    end
                end
            end
            if (!merged) begin
                if (queue_image.size() < QueueDepth) begin
                    e.etype = it.etype;     e.key = it.key;
                    e.pos_x = it.pos_x;     e.pos_y = it.pos_y;
                    e.delta_x = it.delta_x; e.delta_y = it.delta_y;
                    e.payload = it.payload;
                    queue_image.push_back(e);
                end else begin
                    r.dropped = 1'b1;
                end
            end
        end else if (it.func == FUNC_POP) begin
            if (queue_image.size() > 0) begin
                r.out_valid = 1'b1;
                r.ent = queue_image.pop_front();
            end
        end else if (it.func == FUNC_FLUSH) begin
            foreach (queue_image[i]) if (queue_image[i].etype != it.etype) kept.push_back(queue_image[i]);
            queue_image = kept;
        end
        r.pending = 10'(queue_image.size());
        expected_results.push_back(r);
    endtask

    task automatic report_mismatch(input string fld, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h expected %h at %0t", fld, got, want, $realtime);
        error_count++;
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) predict_result(cur_item);
            if (!s_tvalid || s_tready) begin
                if (pending_items.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
                    cur_item = pending_items.pop_front();
                    s_tdata <= {6'b0, cur_item.payload, cur_item.delta_y, cur_item.delta_x,
                                cur_item.pos_y, cur_item.pos_x, cur_item.key,
                                cur_item.etype, cur_item.func};
                    s_tuser <= cur_item.handled;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver with a long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_req && hold_cnt < HoldCycles) begin
            hold_cnt <= hold_cnt + 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // monitor
    always @(posedge aclk) begin
        queue_result_t w;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                $display("unexpected result transfer at %0t", $realtime);
                error_count++;
            end else begin
                w = expected_results.pop_front();
                if (m_tuser[0] !== w.out_valid)
                    report_mismatch("out_valid", 64'(m_tuser[0]), 64'(w.out_valid));
                if (m_tuser[1] !== w.dropped)
                    report_mismatch("dropped", 64'(m_tuser[1]), 64'(w.dropped));
                if (m_tdata[31:0] !== w.ent.etype)
                    report_mismatch("out_type", 64'(m_tdata[31:0]), 64'(w.ent.etype));
                if (m_tdata[95:32] !== w.ent.key)
                    report_mismatch("out_key", m_tdata[95:32], w.ent.key);
                if (m_tdata[127:96] !== w.ent.pos_x)
                    report_mismatch("out_pos_x", 64'(m_tdata[127:96]), 64'(w.ent.pos_x));
                if (m_tdata[159:128] !== w.ent.pos_y)
                    report_mismatch("out_pos_y", 64'(m_tdata[159:128]), 64'(w.ent.pos_y));
                if (m_tdata[191:160] !== w.ent.delta_x)
                    report_mismatch("out_delta_x", 64'(m_tdata[191:160]),
                                    64'(w.ent.delta_x));
                if (m_tdata[223:192] !== w.ent.delta_y)
                    report_mismatch("out_delta_y", 64'(m_tdata[223:192]),
                                    64'(w.ent.delta_y));
                if (m_tdata[287:224] !== w.ent.payload)
                    report_mismatch("out_payload", m_tdata[287:224], w.ent.payload);
                if (m_tdata[297:288] !== w.pending[PendW-1:0])
                    report_mismatch("pending_count", 64'(m_tdata[297:288]), 64'(w.pending));
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WatchLimit) begin
                $display("** coalescing_event_queue_top: FAILED **");
                $finish;
            end
        end
    end

    function automatic event_item_t make_item(input func_t f, input logic [31:0] t,
                                              input logic [63:0] k, input logic [31:0] dx,
                                              input logic [31:0] dy);
        event_item_t it;
        it.func = f; it.etype = t; it.handled = 1'b1; it.key = k;
        it.pos_x = $urandom; it.pos_y = $urandom;
        it.delta_x = dx; it.delta_y = dy;
        it.payload = {$urandom, $urandom};
        return it;
    endfunction

    function automatic logic [31:0] pick_type();
        case ($urandom_range(5))
            0, 1: return pointer_code;
            2, 3: return finger_code;
            4: return $urandom_range(3);
            default: return $urandom;
        endcase
    endfunction

    function automatic event_item_t random_item();
        event_item_t it;
        int          r;
        logic [63:0] k;
        r = $urandom_range(99);
        k = ($urandom_range(7) == 0) ? {$urandom, $urandom} : 64'($urandom_range(3));
        it = make_item(FUNC_PUSH, pick_type(), k, $urandom, $urandom);
        if ($urandom_range(3) == 0) begin
            it.delta_x = $urandom_range(1) ? 32'h7FFF_FF00 : 32'h8000_0100;
            it.delta_y = $urandom_range(1) ? 32'h7FFF_FF00 : 32'h8000_0100;
        end
        if (r < 52) it.handled = ($urandom_range(9) != 0);
        else if (r < 88) it.func = FUNC_POP;
        else if (r < 95) it.func = FUNC_FLUSH;
        else it.func = FUNC_NOP;
        if (it.func != FUNC_PUSH) it.handled = 1'($urandom_range(1));
        return it;
    endfunction

    task automatic wait_idle();
        while (pending_items.size() > 0 || s_tvalid || expected_results.size() > 0)
            @(posedge aclk);
        repeat (DrainWait) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        forever begin
            @(posedge aclk);
            if (cfg_ready) break;
        end
        cfg_valid <= 1'b0;
        if (idx == 1'b0) pointer_code = val;
        else finger_code = val;
    endtask

    task automatic load_random(input int n);
        repeat (n) pending_items.push_back(random_item());
    endtask

    initial begin
        event_item_t it;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        write_reg(1'b0, 32'd1024);
        write_reg(1'b1, 32'd1794);

        // directed
        pending_items.push_back(make_item(FUNC_POP, 0, 0, 0, 0));
        pending_items.push_back(make_item(FUNC_NOP, 0, 0, 0, 0));
        pending_items.push_back(make_item(FUNC_FLUSH, 1024, 0, 0, 0));
        it = make_item(FUNC_PUSH, 1024, 1, 5, 5); it.handled = 1'b0;
        pending_items.push_back(it);
        it = make_item(FUNC_PUSH, 0, 0, 0, 0);
        it.pos_x = 0; it.pos_y = 0; it.payload = 0;
        pending_items.push_back(it);
        it = make_item(FUNC_PUSH, 32'hFFFF_FFFF, '1, 32'h8000_0000, 32'h7FFF_FFFF);
        it.pos_x = 32'h7FFF_FFFF; it.pos_y = 32'h8000_0000; it.payload = '1;
        pending_items.push_back(it);
        pending_items.push_back(make_item(FUNC_PUSH, 1024, 5, 32'h7FFF_FFF0, 32'h8000_0010));
        pending_items.push_back(make_item(FUNC_PUSH, 1024, 5, 32'h100, 32'hFFFF_FF00));
        pending_items.push_back(make_item(FUNC_PUSH, 1794, 5, 32'hFFFF_FFFF, 1));
        pending_items.push_back(make_item(FUNC_PUSH, 1794, 5, 32'h8000_0000, 32'h7FFF_FFFF));
        pending_items.push_back(make_item(FUNC_PUSH, 1024, 6, 3, 3));
        pending_items.push_back(make_item(FUNC_PUSH, 1024, 5, 1, 1));
        pending_items.push_back(make_item(FUNC_FLUSH, 32'd7, 0, 0, 0));
        pending_items.push_back(make_item(FUNC_FLUSH, 1024, 0, 0, 0));
        repeat (5) pending_items.push_back(make_item(FUNC_POP, 0, 0, 0, 0));
        wait_idle();

        write_reg(1'b0, 32'd5);
        write_reg(1'b1, 32'd5);
        load_random(40);
        wait_idle();

        src_idle_pct = 67; snk_idle_pct = 18;
        write_reg(1'b0, 32'd0);
        write_reg(1'b1, 32'hFFFF_FFFF);
        load_random(30);
        wait_idle();

        // fill to full under receiver hold-off, then merge and drop at full
        src_idle_pct = 0; snk_idle_pct = 0;
        write_reg(1'b0, 32'd1024);
        write_reg(1'b1, 32'd1794);
        hold_req <= 1'b1;
        pending_items.push_back(make_item(FUNC_PUSH, 1024, 9, 32'h7000_0000, 1));
        pending_items.push_back(make_item(FUNC_PUSH, 1794, 9, 2, 2));
        for (int i = 0; i < QueueDepth; i++)
            pending_items.push_back(make_item(FUNC_PUSH, 32'd7 + (i % 3), 64'(i),
                                              $urandom, $urandom));
        pending_items.push_back(make_item(FUNC_PUSH, 1024, 9, 32'h7000_0000, 1));
        pending_items.push_back(make_item(FUNC_PUSH, 1794, 9, 3, 3));
        pending_items.push_back(make_item(FUNC_PUSH, 1024, 10, 1, 1));
        pending_items.push_back(make_item(FUNC_PUSH, 32'd7, 0, 1, 1));
        pending_items.push_back(make_item(FUNC_FLUSH, 32'd8, 0, 0, 0));
        pending_items.push_back(make_item(FUNC_FLUSH, 32'd7, 0, 0, 0));
        pending_items.push_back(make_item(FUNC_FLUSH, 32'd9, 0, 0, 0));
        repeat (3) pending_items.push_back(make_item(FUNC_POP, 0, 0, 0, 0));
        wait_idle();

        write_reg(1'b0, $urandom);
        write_reg(1'b1, $urandom);
        load_random(20);
        wait_idle();
        write_reg(1'b0, 32'd3);
        write_reg(1'b1, 32'd2);
        load_random(20);
        wait_idle();

        if (error_count == 0) begin
            $display("** coalescing_event_queue_top: PASSED **");
        end else begin
            $display("** coalescing_event_queue_top: FAILED **");
        end
        $finish;
    end
endmodule
`default_nettype wire
